>>> rtl/unsigned_decimal_field_formatter_assert.svh
// ----------------------------------------------------------------------------
// unsigned decimal field formatter assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UDF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("udf assertion failed");

// next-cycle implication
`define UDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("udf assertion failed");

`else

`define UDF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define UDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/udf_pkg.sv
// ----------------------------------------------------------------------------
// udf_pkg
// shared types and constants of the unsigned decimal field formatter
// ----------------------------------------------------------------------------
package udf_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int ND_W       = 4;
    localparam int FLD_W      = 7;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 8;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } state_t;

    // status of the binary to bcd unit
    typedef struct packed {
        logic busy;
        logic done;
    } dab_stat_t;

endpackage

>>> rtl/udf_dabble.sv
// ----------------------------------------------------------------------------
// udf_dabble
// iterative shift-and-add-3 binary to bcd converter, one bit per cycle
// ----------------------------------------------------------------------------
module udf_dabble (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [udf_pkg::VALUE_W-1:0]         bin_in,
    output udf_pkg::dab_stat_t                  stat,
    output logic [udf_pkg::BCD_W-1:0]           bcd
);

    logic [udf_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [udf_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [udf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic [udf_pkg::BCD_W-1:0]   adj;
    logic                        last_step;

    assign last_step = busy_reg && (cnt_reg == udf_pkg::CNT_W'(udf_pkg::VALUE_W - 1));

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < udf_pkg::NUM_DIGITS; d++) begin
            adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ? (bcd_reg[4*d +: 4] + 4'd3)
                                                        : bcd_reg[4*d +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            bin_next  = bin_in;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next  = {adj[udf_pkg::BCD_W-2:0], bin_reg[udf_pkg::VALUE_W-1]};
            bin_next  = {bin_reg[udf_pkg::VALUE_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            busy_next = !last_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = last_step;
    assign bcd       = bcd_reg;

endmodule

>>> rtl/udf_char.sv
// ----------------------------------------------------------------------------
// udf_char
// picks the character at one field position: padding, leading zero or digit
// ----------------------------------------------------------------------------
module udf_char #(
    parameter int CW = 7
) (
    input  logic [CW-1:0]               pos,
    input  logic [CW-1:0]               pad,
    input  logic [CW-1:0]               ndig,
    input  logic [udf_pkg::ND_W-1:0]    nd,
    input  logic                        left,
    input  logic [7:0]                  pad_ch,
    input  logic [udf_pkg::BCD_W-1:0]   bcd,
    output logic [7:0]                  out_char
);

    logic [CW-1:0]              off;
    logic [CW-1:0]              k;
    logic [udf_pkg::ND_W-1:0]   k4;
    logic [udf_pkg::BCD_W-1:0]  shifted;
    logic                       in_pad;

    always_comb begin
        in_pad   = left ? (pos >= ndig) : (pos < pad);
        off      = left ? pos : (pos - pad);
        k        = ndig - 1'b1 - off;
        k4       = k[udf_pkg::ND_W-1:0];
        shifted  = bcd >> {k4, 2'b00};
        if (in_pad) begin
            out_char = pad_ch;
        end else if (k < CW'(nd)) begin
            out_char = udf_pkg::CHAR_ZERO + {4'd0, shifted[3:0]};
        end else begin
            out_char = udf_pkg::CHAR_ZERO;
        end
    end

endmodule

>>> rtl/unsigned_decimal_field_formatter.sv
// steps: ST_CONV converts the value, ST_SIZE sizes the field, ST_EMIT registers characters onto m_
// no new item is taken until the last character is loaded; one character per cycle while m_ is not stalled
// the conversion is done by the shift-and-add-3 unit taking one value bit per cycle
// s_tready is high only while idle; the last character may still wait on m_ then
// reset: synchronous, active low, clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// printf-style unsigned decimal conversion into a padded ascii field
// ----------------------------------------------------------------------------
`include "unsigned_decimal_field_formatter_assert.svh"

module unsigned_decimal_field_formatter #(
    parameter int MAX_FIELD = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input item
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value[31:0], field_width[38:32], precision[45:39], has_precision[46],
    // left_justify[47], zero_flag[48], unused[55:49]
    input  logic [udf_pkg::S_TDATA_W-1:0]       s_tdata,
    // result item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_char[7:0]
    output logic [udf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    // counter width holds any field length up to the bound
    localparam int CW = $clog2(MAX_FIELD + 1);

    // input fields
    logic [udf_pkg::VALUE_W-1:0] in_value;
    logic [udf_pkg::FLD_W-1:0]   in_width;
    logic [udf_pkg::FLD_W-1:0]   in_prec;
    logic                        in_hasp;
    logic                        in_left;
    logic                        in_zero;

    assign in_value = s_tdata[31:0];
    assign in_width = s_tdata[38:32];
    assign in_prec  = s_tdata[45:39];
    assign in_hasp  = s_tdata[46];
    assign in_left  = s_tdata[47];
    assign in_zero  = s_tdata[48];

    udf_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              width_reg, width_next;
    logic [CW-1:0]              prec_reg, prec_next;
    logic                       hasp_reg, hasp_next;
    logic                       left_reg, left_next;
    logic [7:0]                 padch_reg, padch_next;
    logic [udf_pkg::ND_W-1:0]   nd_reg, nd_next;
    logic [CW-1:0]              ndig_reg, ndig_next;
    logic [CW-1:0]              pad_reg, pad_next;
    logic [CW-1:0]              total_reg, total_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic                       m_valid_reg, m_valid_next;
    logic [7:0]                 m_data_reg, m_data_next;
    logic                       m_last_reg, m_last_next;

    logic                       s_accept;
    logic                       load;
    logic                       is_last;
    logic [CW-1:0]              width_sat;
    logic [CW-1:0]              prec_sat;
    logic [udf_pkg::ND_W-1:0]   nd_raw;
    logic [udf_pkg::ND_W-1:0]   nd_calc;
    logic [CW-1:0]              ndig_calc;
    logic [7:0]                 char_sel;

    udf_pkg::dab_stat_t         dab_stat;
    logic [udf_pkg::BCD_W-1:0]  bcd;

    // single binary to bcd unit
    udf_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .bin_in  (in_value),
        .stat    (dab_stat),
        .bcd     (bcd)
    );

    // character at the current field position
    udf_char #(.CW(CW)) u_char (
        .pos      (pos_reg),
        .pad      (pad_reg),
        .ndig     (ndig_reg),
        .nd       (nd_reg),
        .left     (left_reg),
        .pad_ch   (padch_reg),
        .bcd      (bcd),
        .out_char (char_sel)
    );

    // saturate width and precision at the field bound
    assign width_sat = (32'(in_width) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(in_width);
    assign prec_sat  = (32'(in_prec) > MAX_FIELD) ? CW'(MAX_FIELD) : CW'(in_prec);

    // significant digit count: highest nonzero digit, at least one
    always_comb begin
        nd_raw = udf_pkg::ND_W'(1);
        for (int d = 1; d < udf_pkg::NUM_DIGITS; d++) begin
            if (bcd[4*d +: 4] != 4'd0) begin
                nd_raw = udf_pkg::ND_W'(d + 1);
            end
        end
        // zero with an explicit zero precision prints no digits
        nd_calc   = ((bcd == '0) && hasp_reg && (prec_reg == '0)) ? '0 : nd_raw;
        ndig_calc = (prec_reg > CW'(nd_calc)) ? prec_reg : CW'(nd_calc);
    end

    assign is_last = (pos_reg == (total_reg - 1'b1));

    // fsm outputs
    always_comb begin
        s_tready = (state_reg == udf_pkg::ST_IDLE);
        s_accept = s_tvalid && s_tready;
        load     = (state_reg == udf_pkg::ST_EMIT) && (!m_valid_reg || m_tready);
    end

    // fsm next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            udf_pkg::ST_IDLE: begin
                if (s_accept) state_next = udf_pkg::ST_CONV;
            end
            udf_pkg::ST_CONV: begin
                if (dab_stat.done) state_next = udf_pkg::ST_SIZE;
            end
            udf_pkg::ST_SIZE: begin
                // an empty field gives no items
                state_next = (total_next == '0) ? udf_pkg::ST_IDLE : udf_pkg::ST_EMIT;
            end
            udf_pkg::ST_EMIT: begin
                if (load && is_last) state_next = udf_pkg::ST_IDLE;
            end
            default: state_next = udf_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        width_next   = width_reg;
        prec_next    = prec_reg;
        hasp_next    = hasp_reg;
        left_next    = left_reg;
        padch_next   = padch_reg;
        nd_next      = nd_reg;
        ndig_next    = ndig_reg;
        pad_next     = pad_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;

        if (s_accept) begin
            width_next = width_sat;
            prec_next  = in_hasp ? prec_sat : '0;
            hasp_next  = in_hasp;
            left_next  = in_left;
            // zero padding only right-justified without a precision
            padch_next = (in_zero && !in_left && !in_hasp) ? udf_pkg::CHAR_ZERO
                                                           : udf_pkg::CHAR_SPACE;
        end

        if (state_reg == udf_pkg::ST_SIZE) begin
            nd_next    = nd_calc;
            ndig_next  = ndig_calc;
            pad_next   = (width_reg > ndig_calc) ? (width_reg - ndig_calc) : '0;
            total_next = (width_reg > ndig_calc) ? width_reg : ndig_calc;
            pos_next   = '0;
        end

        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = char_sel;
            m_last_next  = is_last;
            pos_next     = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= udf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
        end
        width_reg  <= width_next;
        prec_reg   <= prec_next;
        hasp_reg   <= hasp_next;
        left_reg   <= left_next;
        padch_reg  <= padch_next;
        nd_reg     <= nd_next;
        ndig_reg   <= ndig_next;
        pad_reg    <= pad_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // converter finishes only while the sequencer waits for it
    `UDF_ASSERT_SAME(a_done_in_conv, aclk, aresetn, dab_stat.done, state_reg == udf_pkg::ST_CONV)
    // position stays inside the field while emitting
    `UDF_ASSERT_SAME(a_pos_in_field, aclk, aresetn, state_reg == udf_pkg::ST_EMIT, pos_reg < total_reg)
    // loading the final character returns the sequencer to idle
    `UDF_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, load && is_last, state_reg == udf_pkg::ST_IDLE && m_tlast)
    // an accepted item starts the converter
    `UDF_ASSERT_NEXT(a_accept_conv, aclk, aresetn, s_accept, dab_stat.busy && state_reg == udf_pkg::ST_CONV)

endmodule

>>> verif/tb_unsigned_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// tb_unsigned_decimal_field_formatter
// drives directed and random format requests into the formatter, predicts the
// padded decimal field of each accepted item and checks every character and
// its last marker in order, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module tb_unsigned_decimal_field_formatter;

    localparam int FIELD_MAX  = 64;
    localparam int DIR_N      = 25;
    localparam int RAND_N     = 255;
    localparam int DRAIN_CYC  = 120;
    localparam int IDLE_LIMIT = 4000;

    // input item as packed in s_tdata, lowest field last
    typedef struct packed {
        logic [6:0]  fill;
        logic        zero_flag;
        logic        left_justify;
        logic        has_precision;
        logic [6:0]  precision;
        logic [6:0]  field_width;
        logic [31:0] value;
    } fmt_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    // literal text, right aligned, leading zero bytes unused
    typedef struct packed {
        logic         use_lit;
        logic [127:0] lit;
    } lit_text_t;

    typedef struct packed {
        logic [31:0]  value;
        logic [6:0]   field_width;
        logic [6:0]   precision;
        logic         has_precision;
        logic         left_justify;
        logic         zero_flag;
        logic         use_lit;
        logic [127:0] lit;
    } dir_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [udf_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [udf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    field_char_t field_chars_q [$];
    lit_text_t   lit_q [$];
    int          err_cnt = 0;
    int          idle_cnt = 0;
    int          burst_left = 0;

    // value, width, precision, has_precision, left, zero, literal?, literal text
    dir_row_t dir_tab [DIR_N] = '{
        '{32'd0,          7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "0"},
        '{32'd0,          7'd0,   7'd0,   1'b1, 1'b0, 1'b0, 1'b1, 128'h0},
        '{32'd0,          7'd3,   7'd0,   1'b1, 1'b0, 1'b0, 1'b1, "   "},
        '{32'd0,          7'd2,   7'd0,   1'b1, 1'b0, 1'b1, 1'b1, "  "},
        '{32'd0,          7'd4,   7'd0,   1'b0, 1'b0, 1'b1, 1'b1, "0000"},
        '{32'd0,          7'd0,   7'd1,   1'b1, 1'b0, 1'b0, 1'b1, "0"},
        '{32'hFFFFFFFF,   7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "4294967295"},
        '{32'd1000000000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "1000000000"},
        '{32'd42,         7'd5,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "   42"},
        '{32'd42,         7'd5,   7'd0,   1'b0, 1'b1, 1'b0, 1'b1, "42   "},
        '{32'd42,         7'd5,   7'd0,   1'b0, 1'b0, 1'b1, 1'b1, "00042"},
        '{32'd42,         7'd5,   7'd0,   1'b0, 1'b1, 1'b1, 1'b1, "42   "},
        '{32'd42,         7'd5,   7'd0,   1'b1, 1'b0, 1'b1, 1'b1, "   42"},
        '{32'd42,         7'd0,   7'd5,   1'b1, 1'b0, 1'b0, 1'b1, "00042"},
        '{32'd42,         7'd0,   7'd5,   1'b0, 1'b0, 1'b0, 1'b1, "42"},
        '{32'd7,          7'd8,   7'd4,   1'b1, 1'b1, 1'b0, 1'b1, "0007    "},
        '{32'd99999,      7'd3,   7'd0,   1'b0, 1'b0, 1'b1, 1'b1, "99999"},
        '{32'd9,          7'd1,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, "9"},
        '{32'd10,         7'd0,   7'd2,   1'b1, 1'b0, 1'b1, 1'b1, "10"},
        // saturated width and precision, checked against the predictor
        '{32'd123,        7'd127, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0, 128'h0},
        '{32'd123,        7'd0,   7'd127, 1'b1, 1'b0, 1'b0, 1'b0, 128'h0},
        '{32'hFFFFFFFF,   7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b0, 128'h0},
        '{32'd5,          7'd64,  7'd0,   1'b0, 1'b0, 1'b1, 1'b0, 128'h0},
        '{32'd3,          7'd65,  7'd70,  1'b1, 1'b1, 1'b0, 1'b0, 128'h0},
        '{32'd0,          7'd127, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, 128'h0}
    };

    unsigned_decimal_field_formatter #(
        .MAX_FIELD (FIELD_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // queues the characters of the padded decimal field for one request
    function automatic void format_udec(input fmt_req_t r);
        logic [3:0]  digs [udf_pkg::NUM_DIGITS];
        logic [31:0] v;
        logic [7:0]  pad_ch;
        logic [7:0]  ch;
        int          wid;
        int          prec;
        int          nd;
        int          ndig;
        int          pad;
        int          total;
        int          k;
        wid  = (int'(r.field_width) > FIELD_MAX) ? FIELD_MAX : int'(r.field_width);
        prec = 0;
        if (r.has_precision) begin
            prec = (int'(r.precision) > FIELD_MAX) ? FIELD_MAX : int'(r.precision);
        end
        v  = r.value;
        nd = 0;
        do begin
            digs[nd] = 4'(v % 32'd10);
            v = v / 32'd10;
            nd++;
        end while (v != 0);
        // zero with an explicit zero precision prints no digits
        if (r.value == 0 && r.has_precision && prec == 0) begin
            nd = 0;
        end
        ndig   = (prec > nd) ? prec : nd;
        pad    = (wid > ndig) ? wid - ndig : 0;
        total  = ndig + pad;
        pad_ch = (r.zero_flag && !r.left_justify && !r.has_precision) ? udf_pkg::CHAR_ZERO
                                                                       : udf_pkg::CHAR_SPACE;
        for (int i = 0; i < total; i++) begin
            if (!r.left_justify && i < pad) begin
                ch = pad_ch;
            end else if (r.left_justify && i >= ndig) begin
                ch = pad_ch;
            end else begin
                k  = r.left_justify ? i : i - pad;
                k  = ndig - 1 - k;
                ch = (k < nd) ? udf_pkg::CHAR_ZERO + 8'(digs[k]) : udf_pkg::CHAR_ZERO;
            end
            field_chars_q.push_back('{ch, (i == total - 1)});
        end
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic send_req(input fmt_req_t r, input logic use_lit, input logic [127:0] lit);
        lit_q.push_back('{use_lit, lit});
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
    endtask

    // input side: expectation for each accepted item
    always @(posedge aclk) begin
        lit_text_t t;
        int        n;
        if (aresetn && s_tvalid && s_tready) begin
            t = lit_q.pop_front();
            if (t.use_lit) begin
                n = 0;
                for (int b = 0; b < 16; b++) begin
                    if (t.lit[b*8 +: 8] != 8'h00) n++;
                end
                for (int b = n - 1; b >= 0; b--) begin
                    field_chars_q.push_back('{t.lit[b*8 +: 8], (b == 0)});
                end
            end else begin
                format_udec(fmt_req_t'(s_tdata));
            end
        end
    end

    // result side: compare each accepted character with the oldest expectation
    always @(posedge aclk) begin
        field_char_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (field_chars_q.size() == 0) begin
                $display("%0t unexpected char %h last %b", $time, m_tdata, m_tlast);
                err_cnt++;
            end else begin
                e = field_chars_q.pop_front();
                if (e.ch !== m_tdata || e.last !== m_tlast) begin
                    $display("%0t expected char %h last %b, actual char %h last %b",
                             $time, e.ch, e.last, m_tdata, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls: a randomly chosen ready mode, redrawn when its run ends
    always @(posedge aclk) begin
        int rdy_mode;
        int mode_cyc;
        int stall_left;
        if (mode_cyc == 0) begin
            rdy_mode = $urandom_range(0, 2);
            mode_cyc = $urandom_range(50, 400);
        end
        mode_cyc--;
        case (rdy_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 20);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // watchdog: cycles with no accept on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        fmt_req_t    r;
        logic [31:0] p;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        for (int i = 0; i < DIR_N; i++) begin
            r = '0;
            r.value         = dir_tab[i].value;
            r.field_width   = dir_tab[i].field_width;
            r.precision     = dir_tab[i].precision;
            r.has_precision = dir_tab[i].has_precision;
            r.left_justify  = dir_tab[i].left_justify;
            r.zero_flag     = dir_tab[i].zero_flag;
            send_req(r, dir_tab[i].use_lit, dir_tab[i].lit);
        end

        // random requests, mostly short fields
        for (int i = 0; i < RAND_N; i++) begin
            r = '0;
            case ($urandom_range(0, 5))
                0: r.value = 32'd0;
                1: r.value = $urandom_range(0, 99);
                2: r.value = $urandom;
                3: begin
                    p = 32'd1;
                    repeat ($urandom_range(1, 9)) p = p * 32'd10;
                    r.value = p - $urandom_range(0, 1);
                end
                default: r.value = $urandom >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 9))
                0:       r.field_width = 7'($urandom_range(0, 127));
                1, 2:    r.field_width = 7'($urandom_range(0, 64));
                default: r.field_width = 7'($urandom_range(0, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       r.precision = 7'($urandom_range(0, 127));
                1, 2:    r.precision = 7'($urandom_range(0, 64));
                default: r.precision = 7'($urandom_range(0, 12));
            endcase
            r.has_precision = 1'($urandom_range(0, 1));
            r.left_justify  = 1'($urandom_range(0, 1));
            r.zero_flag     = 1'($urandom_range(0, 1));
            send_req(r, 1'b0, 128'h0);
        end
        s_tvalid <= 1'b0;

        // let the last accepted item reach the expectation queue first
        @(posedge aclk);
        while (field_chars_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (err_cnt == 0 && field_chars_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
